>>> hdl/clkdps_pkg.sv
`timescale 1ns / 1ps

package clkdps_pkg;

  // search ranges of the two dividers
  localparam int unsigned MAX_FIRST_DIV  = 63;
  localparam int unsigned MAX_SECOND_DIV = 31;

  localparam int unsigned FIRST_CNT_W  = $clog2(MAX_FIRST_DIV + 1);
  localparam int unsigned SECOND_CNT_W = $clog2(MAX_SECOND_DIV + 1);

  // control word layout
  localparam int unsigned RATE_W       = 32;
  localparam int unsigned CTRL_W       = 32;
  localparam int unsigned FIELD_W      = 6;
  localparam int unsigned FIRST_OUT_W  = 6;
  localparam int unsigned SECOND_OUT_W = 5;
  localparam int unsigned FIRST_SHIFT  = 8;
  localparam int unsigned SECOND_SHIFT = 20;
  localparam logic [CTRL_W-1:0] FIELD_MASK = CTRL_W'(6'h3f);

  // shared divider widths: numerator carries the rounding half
  localparam int unsigned NUM_W = RATE_W + 1;
  localparam int unsigned DEN_W = RATE_W;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);

  typedef struct packed {
    logic [RATE_W-1:0] parent_rate;
    logic [RATE_W-1:0] target_rate;
    logic              two_dividers;
    logic [CTRL_W-1:0] old_control;
  } in_item_t;

  typedef struct packed {
    logic [CTRL_W-1:0]       new_control;
    logic [FIRST_OUT_W-1:0]  first_divider;
    logic [SECOND_OUT_W-1:0] second_divider;
    logic [RATE_W-1:0]       achieved_rate;
    logic                    bad_target;
  } out_item_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> hdl/clkdps_div.sv
`timescale 1ns / 1ps

module clkdps_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  clkdps_pkg::div_req_t req_i,
  output clkdps_pkg::div_rsp_t rsp_o
);
  import clkdps_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 done_q;
  logic [DEN_W-1:0]     rem_q;
  logic [NUM_W-1:0]     quo_q;
  logic [DEN_W-1:0]     den_q;
  logic                 dz_q;

  logic [DEN_W:0] shifted;
  logic [DEN_W:0] diff;
  logic           fits;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    shifted = {rem_q, quo_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = shifted >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.go) begin
        cnt_q <= DIV_CNT_W'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.go) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
      dz_q  <= (req_i.den == '0);
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  // a zero divisor gives a zero quotient
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dz_q ? '0 : quo_q;

endmodule

>>> hdl/clock_divider_pair_search_unit.sv
`timescale 1ns / 1ps

// clock divider pair search: an item is taken when start is high and busy is low;
// the result shows on result_o for exactly one cycle with res_valid_o high and
// cannot be held off, so the receiver must take it in that cycle. all work goes
// through one shared restoring divider that retires one quotient bit a cycle.
// two-divider mode runs 63 first-stage divisions plus 63 x 31 pair divisions,
// each pair followed by an error step and a best-pair compare. one-divider mode
// takes two divisions. a zero target in one-divider mode is answered in the
// cycle after the item, with busy never raised.
module clock_divider_pair_search_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  clkdps_pkg::in_item_t  item_i,
  output clkdps_pkg::out_item_t result_o,
  output logic                  res_valid_o
);
  import clkdps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STAGE,
    S_PAIR,
    S_EVAL,
    S_CMP,
    S_ONE_DIV,
    S_ONE_ACH
  } state_e;

  state_e state_q;

  // latched item
  logic [RATE_W-1:0] parent_q;
  logic [RATE_W-1:0] target_q;
  logic [CTRL_W-1:0] ctrl_q;

  // search counters and best pair so far
  logic [FIRST_CNT_W-1:0]  a_q;
  logic [SECOND_CNT_W-1:0] b_q;
  logic [FIRST_CNT_W-1:0]  best_a_q;
  logic [SECOND_CNT_W-1:0] best_b_q;
  logic [RATE_W:0]         min_err_q;
  logic [RATE_W-1:0]       best_rate_q;
  logic [RATE_W-1:0]       stage_q;
  logic [RATE_W-1:0]       rate_q;
  logic [RATE_W-1:0]       err_q;
  logic [FIRST_OUT_W-1:0]  d0_q;

  div_req_t  req_q;
  div_rsp_t  rsp;
  out_item_t res_q;
  logic      res_valid_q;

  clkdps_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // compare of the current pair against the best one, first pair wins ties
  logic                    win;
  logic [FIRST_CNT_W-1:0]  fin_a;
  logic [SECOND_CNT_W-1:0] fin_b;
  logic [RATE_W-1:0]       fin_rate;
  logic [31:0]             fin_a_ext;
  logic [31:0]             fin_b_ext;
  logic [FIRST_CNT_W-1:0]  a_nxt;
  logic [SECOND_CNT_W-1:0] b_nxt;
  logic [CTRL_W-1:0]       two_ctrl;

  always_comb begin
    win       = {1'b0, err_q} < min_err_q;
    fin_a     = win ? a_q : best_a_q;
    fin_b     = win ? b_q : best_b_q;
    fin_rate  = win ? rate_q : best_rate_q;
    fin_a_ext = 32'(fin_a);
    fin_b_ext = 32'(fin_b);
    a_nxt     = a_q + 1'b1;
    b_nxt     = b_q + 1'b1;
    // both divider fields replaced, each masked to the field width
    two_ctrl  = (ctrl_q & ~(FIELD_MASK << FIRST_SHIFT) & ~(FIELD_MASK << SECOND_SHIFT))
              | (CTRL_W'(fin_a_ext[FIELD_W-1:0]) << FIRST_SHIFT)
              | (CTRL_W'(fin_b_ext[FIELD_W-1:0]) << SECOND_SHIFT);
  end

  // one-divider mode: the rounded divider masked to the field, zero forced to one
  logic [FIRST_OUT_W-1:0] one_d0;
  always_comb begin
    one_d0 = rsp.quot[FIRST_OUT_W-1:0];
    if (one_d0 == '0) begin
      one_d0 = FIRST_OUT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q.go    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_q.go    <= 1'b0;
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            parent_q <= item_i.parent_rate;
            target_q <= item_i.target_rate;
            ctrl_q   <= item_i.old_control;
            if (item_i.two_dividers) begin
              // first stage with d0 = 1
              a_q         <= FIRST_CNT_W'(1);
              min_err_q   <= '1;
              best_a_q    <= '0;
              best_b_q    <= '0;
              best_rate_q <= '0;
              req_q.go    <= 1'b1;
              req_q.num   <= NUM_W'(item_i.parent_rate);
              req_q.den   <= DEN_W'(1);
              state_q     <= S_STAGE;
            end else if (item_i.target_rate == '0) begin
              // zero target: flag only, control word untouched
              res_q.new_control    <= item_i.old_control;
              res_q.first_divider  <= '0;
              res_q.second_divider <= '0;
              res_q.achieved_rate  <= '0;
              res_q.bad_target     <= 1'b1;
              res_valid_q          <= 1'b1;
            end else begin
              req_q.go  <= 1'b1;
              req_q.num <= NUM_W'(item_i.parent_rate) + NUM_W'(item_i.target_rate >> 1);
              req_q.den <= item_i.target_rate;
              state_q   <= S_ONE_DIV;
            end
          end
        end

        S_STAGE: begin
          if (rsp.done) begin
            stage_q   <= rsp.quot[RATE_W-1:0];
            b_q       <= SECOND_CNT_W'(1);
            req_q.go  <= 1'b1;
            req_q.num <= NUM_W'(rsp.quot[RATE_W-1:0]);
            req_q.den <= DEN_W'(1);
            state_q   <= S_PAIR;
          end
        end

        S_PAIR: begin
          if (rsp.done) begin
            rate_q  <= rsp.quot[RATE_W-1:0];
            state_q <= S_EVAL;
          end
        end

        S_EVAL: begin
          // absolute error of this pair
          err_q   <= (rate_q >= target_q) ? (rate_q - target_q) : (target_q - rate_q);
          state_q <= S_CMP;
        end

        S_CMP: begin
          min_err_q   <= win ? {1'b0, err_q} : min_err_q;
          best_a_q    <= fin_a;
          best_b_q    <= fin_b;
          best_rate_q <= fin_rate;
          if (b_q != SECOND_CNT_W'(MAX_SECOND_DIV)) begin
            // next second divider over the same stage rate
            b_q       <= b_nxt;
            req_q.go  <= 1'b1;
            req_q.num <= NUM_W'(stage_q) + NUM_W'(b_nxt >> 1);
            req_q.den <= DEN_W'(b_nxt);
            state_q   <= S_PAIR;
          end else if (a_q != FIRST_CNT_W'(MAX_FIRST_DIV)) begin
            // next first divider, new stage rate
            a_q       <= a_nxt;
            req_q.go  <= 1'b1;
            req_q.num <= NUM_W'(parent_q) + NUM_W'(a_nxt >> 1);
            req_q.den <= DEN_W'(a_nxt);
            state_q   <= S_STAGE;
          end else begin
            res_q.new_control    <= two_ctrl;
            res_q.first_divider  <= fin_a_ext[FIRST_OUT_W-1:0];
            res_q.second_divider <= fin_b_ext[SECOND_OUT_W-1:0];
            res_q.achieved_rate  <= fin_rate;
            res_q.bad_target     <= 1'b0;
            res_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end

        S_ONE_DIV: begin
          if (rsp.done) begin
            d0_q      <= one_d0;
            req_q.go  <= 1'b1;
            req_q.num <= NUM_W'(parent_q) + NUM_W'(one_d0 >> 1);
            req_q.den <= DEN_W'(one_d0);
            state_q   <= S_ONE_ACH;
          end
        end

        S_ONE_ACH: begin
          if (rsp.done) begin
            // only the first divider field is replaced
            res_q.new_control    <= (ctrl_q & ~(FIELD_MASK << FIRST_SHIFT))
                                  | (CTRL_W'(d0_q) << FIRST_SHIFT);
            res_q.first_divider  <= d0_q;
            res_q.second_divider <= '0;
            res_q.achieved_rate  <= rsp.quot[RATE_W-1:0];
            res_q.bad_target     <= 1'b0;
            res_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign result_o    = res_q;
  assign res_valid_o = res_valid_q;

endmodule

>>> hdl/clkdps_chk.sv
`timescale 1ns / 1ps

module clkdps_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input clkdps_pkg::in_item_t  item_i,
  input clkdps_pkg::out_item_t result_o,
  input logic                  res_valid_o
);
  import clkdps_pkg::*;

  // results only appear once the block is free again
  a_valid_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result shown while busy");

  // a finished search always hands back its item
  a_busy_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o)
    else $error("search ended without a result");

  // zero target in one-divider mode is answered right away with the flag
  a_bad_target_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !item_i.two_dividers && item_i.target_rate == '0)
      |=> (res_valid_o && result_o.bad_target && !busy))
    else $error("zero target not flagged");

  // flagged items carry no divider or rate
  a_bad_target_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.bad_target) |->
      (result_o.first_divider == '0 && result_o.second_divider == '0 &&
       result_o.achieved_rate == '0))
    else $error("flagged item has nonzero fields");

endmodule

bind clock_divider_pair_search_unit clkdps_chk u_clkdps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .item_i      (item_i),
  .result_o    (result_o),
  .res_valid_o (res_valid_o)
);
